FILE: hw/rtl/cam_phaser_cold_response_monitor_macros.svh
// Assertion macros for the cam phaser cold response monitor.
`ifndef CAM_PHASER_COLD_RESPONSE_MONITOR_MACROS_SVH
`define CAM_PHASER_COLD_RESPONSE_MONITOR_MACROS_SVH

// Clocked assertion, disabled while reset is low.
`define CPCRM_ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) prop) \
        else $error(msg);

// Same, on the block's own clock and reset.
`define CPCRM_ASSERT(label, prop, msg) \
    `CPCRM_ASSERT_CLK(label, clk, rst_n, prop, msg)

`endif

FILE: hw/rtl/cpcrm_pkg.sv
package cpcrm_pkg;

    localparam int REQ_W      = 8;
    localparam int EST_W      = 16;
    localparam int SPEED_W    = 16;
    localparam int OIL_W      = 16;
    localparam int AMP_W      = 8;
    localparam int DELAY_W    = 8;
    localparam int PROD_W     = 15;
    localparam int REM_W      = 8;
    localparam int DIV_CNT_W  = $clog2(PROD_W);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int NUM_STAGES = 3;
    localparam int FLAG_W     = 5;

    localparam logic [REQ_W-1:0]   ANGLE_BIAS  = 8'd128;
    localparam logic [PROD_W-1:0]  DELAY_SCALE = 15'd75;
    localparam logic [DELAY_W-1:0] DELAY_MAX   = 8'd255;
    localparam logic [13:0]        RND_HALF    = 14'd4;
    localparam logic [13:0]        CLAMP_POS   = 14'd127;
    localparam logic [13:0]        CLAMP_NEG   = 14'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_SPEED = 3'd0,
        CFG_MAX_OIL   = 3'd1,
        CFG_MIN_AMP   = 3'd2,
        CFG_GAIN      = 3'd3,
        CFG_OFFSET    = 3'd4,
        CFG_MAX_ERR   = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } status_t;

endpackage

FILE: hw/rtl/cpcrm_div.sv
module cpcrm_div
    import cpcrm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [REM_W-1:0]  divisor,
    output logic              last,
    output logic [PROD_W-1:0] quotient
);

    logic                 busy_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [REM_W-1:0]     dvs_reg;
    logic [REM_W:0]       trial;
    logic                 ge;

    assign trial    = {rem_reg, quo_reg[PROD_W-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign last     = busy_reg && (cnt_reg == DIV_CNT_W'(PROD_W - 1));
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? REM_W'(trial - {1'b0, dvs_reg}) : trial[REM_W-1:0];
            quo_reg <= {quo_reg[PROD_W-2:0], ge};
        end
    end

endmodule

FILE: hw/rtl/cpcrm_ctrl.sv
module cpcrm_ctrl
    import cpcrm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    s_tvalid,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready   = 1'b0;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_DIV:
            begin
            end
            ST_FIN:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hw/rtl/cpcrm_dp.sv
module cpcrm_dp
    import cpcrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  cmd_t                  cmd,
    output status_t               status
);

    // configuration
    logic [SPEED_W-1:0]        min_speed_reg;
    logic signed [OIL_W-1:0]   max_oil_reg;
    logic [AMP_W-1:0]          min_amp_reg;
    logic [REM_W-1:0]          gain_reg;
    logic [DELAY_W-1:0]        offset_reg;
    logic [AMP_W-1:0]          max_err_reg;

    // captured input
    logic [REQ_W-1:0]          req_in_reg;
    logic signed [EST_W-1:0]   est_in_reg;
    logic                      servo_in_reg;
    logic [SPEED_W-1:0]        speed_in_reg;
    logic signed [OIL_W-1:0]   oil_in_reg;
    logic                      inhibit_in_reg;

    // tracking state
    logic [REQ_W-1:0]          last_req_reg;
    logic                      last_step_reg;
    logic signed [REQ_W-1:0]   init_reg;
    logic signed [REQ_W-1:0]   init_next;
    logic                      last_armed_reg;
    logic [DELAY_W-1:0]        cnt_reg  [NUM_STAGES];
    logic [DELAY_W-1:0]        cnt_next [NUM_STAGES];
    logic [NUM_STAGES-1:0]     exp_reg;
    logic [NUM_STAGES-1:0]     exp_next;
    logic [NUM_STAGES-1:0]     flt_reg;
    logic [NUM_STAGES-1:0]     flt_next;
    logic [FLAG_W-1:0]         flags_reg;
    logic [FLAG_W-1:0]         flags_next;

    // per-item results
    logic                      active_reg;
    logic                      step_reg;
    logic [AMP_W-1:0]          amp_reg;
    logic                      rising_reg;
    logic                      afault_reg;

    logic                      m_tvalid_reg;
    logic [OUT_DATA_W-1:0]     m_tdata_reg;

    // prep logic
    logic                      changed;
    logic                      step;
    logic signed [REQ_W-1:0]   req_s;
    logic signed [REQ_W:0]     diff;
    logic [AMP_W-1:0]          amp;
    logic signed [OIL_W-1:0]   oil_div;
    logic                      active;
    logic                      armed;
    logic [EST_W:0]            est_abs;
    logic [13:0]               rnd;
    logic [13:0]               lim;
    logic [REQ_W-1:0]          rcl;
    logic signed [REQ_W:0]     rval;
    logic signed [REQ_W+1:0]   err;
    logic [REQ_W+1:0]          err_abs;
    logic                      afault;
    logic [PROD_W-1:0]         prod;

    // finish logic
    logic [PROD_W-1:0]         quotient;
    logic [PROD_W:0]           d1_sum;
    logic [DELAY_W:0]          d2_sum;
    logic [DELAY_W:0]          d3_sum;
    logic [DELAY_W-1:0]        delay [NUM_STAGES];
    logic                      div_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_speed_reg <= '0;
            max_oil_reg   <= '0;
            min_amp_reg   <= '0;
            gain_reg      <= '0;
            offset_reg    <= '0;
            max_err_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_SPEED: min_speed_reg <= cfg_data;
                CFG_MAX_OIL:   max_oil_reg   <= signed'(cfg_data);
                CFG_MIN_AMP:   min_amp_reg   <= cfg_data[AMP_W-1:0];
                CFG_GAIN:      gain_reg      <= cfg_data[REM_W-1:0];
                CFG_OFFSET:    offset_reg    <= cfg_data[DELAY_W-1:0];
                CFG_MAX_ERR:   max_err_reg   <= cfg_data[AMP_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // tdata: req[7:0], est[23:8], servo[24], speed[40:25], oil[56:41], inhibit[57]
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_in_reg     <= s_tdata[7:0];
            est_in_reg     <= signed'(s_tdata[23:8]);
            servo_in_reg   <= s_tdata[24];
            speed_in_reg   <= s_tdata[40:25];
            oil_in_reg     <= signed'(s_tdata[56:41]);
            inhibit_in_reg <= s_tdata[57];
        end
    end

    always_comb
    begin
        changed   = req_in_reg != last_req_reg;
        step      = changed && !last_step_reg;
        init_next = step ? signed'(last_req_reg ^ ANGLE_BIAS) : init_reg;
        req_s     = signed'(req_in_reg ^ ANGLE_BIAS);
        diff      = {init_next[REQ_W-1], init_next} - {req_s[REQ_W-1], req_s};
        amp       = diff[REQ_W] ? AMP_W'(-diff) : AMP_W'(diff);

        oil_div   = oil_in_reg[OIL_W-1] ? ((oil_in_reg + 16'sd3) >>> 2) : (oil_in_reg >>> 2);
        active    = servo_in_reg && (speed_in_reg > min_speed_reg) &&
                    (oil_div < max_oil_reg) && (amp > min_amp_reg) && !inhibit_in_reg;
        armed     = active && step;

        est_abs   = est_in_reg[EST_W-1] ? (EST_W+1)'(-{est_in_reg[EST_W-1], est_in_reg})
                                        : {1'b0, est_in_reg};
        rnd       = 14'((est_abs + (EST_W+1)'(RND_HALF)) >> 3);
        lim       = est_in_reg[EST_W-1] ? CLAMP_NEG : CLAMP_POS;
        rcl       = (rnd > lim) ? lim[REQ_W-1:0] : rnd[REQ_W-1:0];
        rval      = est_in_reg[EST_W-1] ? -signed'({1'b0, rcl}) : signed'({1'b0, rcl});
        err       = {rval[REQ_W], rval} - {{2{req_s[REQ_W-1]}}, req_s};
        err_abs   = err[REQ_W+1] ? (REQ_W+2)'(-err) : (REQ_W+2)'(err);
        afault    = err_abs > {2'b00, max_err_reg};

        prod      = PROD_W'(amp) * DELAY_SCALE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_req_reg   <= '0;
            last_step_reg  <= 1'b0;
            init_reg       <= '0;
            last_armed_reg <= 1'b0;
        end
        else if (cmd.prep)
        begin
            last_req_reg   <= req_in_reg;
            last_step_reg  <= changed;
            init_reg       <= init_next;
            last_armed_reg <= armed;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            active_reg <= active;
            step_reg   <= step;
            amp_reg    <= amp;
            rising_reg <= armed && !last_armed_reg;
            afault_reg <= afault;
        end
    end

    cpcrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.prep),
        .dividend (prod),
        .divisor  (gain_reg),
        .last     (div_last),
        .quotient (quotient)
    );

    always_comb
    begin
        d1_sum   = (PROD_W+1)'(quotient) + (PROD_W+1)'(offset_reg);
        if (gain_reg == '0)
        begin
            delay[0] = DELAY_MAX;
        end
        else
        begin
            delay[0] = (d1_sum > (PROD_W+1)'(DELAY_MAX)) ? DELAY_MAX : d1_sum[DELAY_W-1:0];
        end
        d2_sum   = {1'b0, offset_reg} + {1'b0, delay[0]};
        delay[1] = d2_sum[DELAY_W] ? DELAY_MAX : d2_sum[DELAY_W-1:0];
        d3_sum   = {1'b0, offset_reg} + {1'b0, delay[1]};
        delay[2] = d3_sum[DELAY_W] ? DELAY_MAX : d3_sum[DELAY_W-1:0];
    end

    always_comb
    begin
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            exp_next[i] = exp_reg[i];
            flt_next[i] = flt_reg[i];
            if (active_reg && (rising_reg || (cnt_reg[i] != '0)))
            begin
                cnt_next[i] = rising_reg ? delay[i] : cnt_reg[i] - 1'b1;
                exp_next[i] = (cnt_next[i] == '0);
                if (exp_next[i] && !exp_reg[i])
                begin
                    flt_next[i] = afault_reg;
                end
            end
        end
        flags_next = flags_reg;
        if (active_reg)
        begin
            flags_next[0] = |flt_next;
            flags_next[1] = flt_next[0] && !flt_next[1] && !flt_next[2];
            flags_next[2] = flt_next[0] && flt_next[1] && !flt_next[2];
            flags_next[3] = flt_next[2];
            flags_next[4] = !flt_next[0] && flt_next[1] && !flt_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                cnt_reg[i] <= '0;
            end
            exp_reg   <= '0;
            flt_reg   <= '0;
            flags_reg <= '0;
        end
        else if (cmd.finish)
        begin
            for (int i = 0; i < NUM_STAGES; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
            exp_reg   <= exp_next;
            flt_reg   <= flt_next;
            flags_reg <= flags_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_tdata_reg <= {1'b0, flags_next, amp_reg, step_reg, active_reg};
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_tdata         = m_tdata_reg;
    assign status.div_last = div_last;
    assign status.out_free = !m_tvalid_reg || m_tready;

endmodule

FILE: hw/rtl/cam_phaser_cold_response_monitor.sv
// Cold-temperature response monitor for an intake cam phaser.
// Input stream (s_*): one transfer per control tick with the requested and
// estimated cam angle, servo state, engine speed, oil temperature, inhibit.
// Output stream (m_*): one transfer per input tick with the activation flag,
// set-point step flag, step amplitude and the five fault class flags.
// Configuration: cfg_we writes cfg_data to the register at cfg_index
// (0 min speed, 1 max oil temp, 2 min amplitude, 3 gain, 4 offset,
// 5 max angle error); write only while no tick is in flight.
// One tick is handled at a time; s_tready returns high with the result.
// Each tick runs prep, the 15-step restoring divider for amp*75/gain, finish.
// A finished result sits in the output register while the next tick is
// accepted; if the receiver still stalls when that tick completes, the
// block holds it until the output register frees.
// Reset zeroes the configuration, tracking state, countdowns, faults and valid flag.
module cam_phaser_cold_response_monitor
    import cpcrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // req[7:0], est[23:8], servo[24], speed[40:25], oil[56:41], inhibit[57]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // running[0], step[1], amp[9:2], any[10], slow1[11], slow2[12], range[13], cmd[14]
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    cpcrm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    cpcrm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

FILE: hw/rtl/cpcrm_chk.sv
`include "cam_phaser_cold_response_monitor_macros.svh"

module cpcrm_chk
    import cpcrm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata
);

    logic       in_xfer;
    logic [3:0] classes;
    logic       classes_ok;

    assign in_xfer    = s_tvalid && s_tready;
    assign classes    = m_tdata[14:11];
    assign classes_ok = $onehot0(classes) && (m_tdata[10] == (|classes));

    `CPCRM_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
    `CPCRM_ASSERT(a_one_at_a_time, in_xfer |=> !s_tready, "tick accepted while one in flight")
    `CPCRM_ASSERT(a_result_after_work, $rose(m_tvalid) |-> $past(!s_tready), "result without work")
    `CPCRM_ASSERT(a_fault_classes, m_tvalid |-> classes_ok, "fault classes inconsistent")

endmodule

bind cam_phaser_cold_response_monitor cpcrm_chk u_chk (.*);
